>>> src/indexed_list_insert_delete_macros.svh
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, held off during reset
`define ILID_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ILID_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ilid_pkg.sv
package ilid_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int OPCODE_BITS = 2;
    localparam int INDEX_BITS  = 5;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 5;
    localparam int STATUS_BITS = 2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // broadcast to every cell for one accepted item
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

>>> src/ilid_cell.sv
module ilid_cell #(
    parameter int WORD_BITS = ilid_pkg::WORD_BITS_DEF,
    parameter int XW        = ilid_pkg::INDEX_BITS,
    parameter int INDEX     = 0
) (
    input  logic                    aclk,
    input  ilid_pkg::cell_ctrl_t    ctrl,
    input  logic [XW-1:0]           idx,
    input  logic [WORD_BITS-1:0]    value,
    input  logic [WORD_BITS-1:0]    left_entry,
    input  logic [WORD_BITS-1:0]    right_entry,
    output logic [WORD_BITS-1:0]    entry,
    output logic [WORD_BITS-1:0]    rd_part
);

    localparam logic [XW-1:0] POS = XW'(INDEX);

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;
    logic                 hit;
    logic                 above;
    logic                 below;

    assign hit   = (idx == POS);
    assign above = (idx < POS);
    assign below = (POS < idx);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.wr_en && hit) begin
            entry_next = value;
        end else if (ctrl.ins_en) begin
            if (hit) begin
                entry_next = value;
            end else if (above) begin
                entry_next = left_entry;
            end
        end else if (ctrl.del_en && !below) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_part = (ctrl.rd_en && hit) ? entry_reg : '0;

endmodule

>>> src/indexed_list_insert_delete.sv
// Ordered list of up to CAPACITY words held in a row of cells, one word per
// cell, with a live count. Every request (read, overwrite, insert, delete) is
// applied to all cells in the cycle it is accepted, so the block takes one item
// per clock while results are taken; the result appears in the output register
// on the next cycle and a new item is taken while that result waits, as long
// as it is taken in the same cycle. Insert and delete shift the cells from the
// index on by one place in parallel. Failed requests leave the list unchanged
// and report the reason in m_status. The stored words are not cleared by reset;
// only the count and m_valid are, so the block is ready straight after reset.
module indexed_list_insert_delete #(
    parameter int CAPACITY  = ilid_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ilid_pkg::WORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ilid_pkg::OPCODE_BITS-1:0]  s_opcode,
    input  logic [ilid_pkg::INDEX_BITS-1:0]   s_index,
    input  logic [ilid_pkg::VALUE_BITS-1:0]   s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ilid_pkg::VALUE_BITS-1:0]   m_read_data,
    output logic [ilid_pkg::COUNT_BITS-1:0]   m_count,
    output logic                              m_past_end,
    output logic [ilid_pkg::STATUS_BITS-1:0]  m_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ilid_pkg::INDEX_BITS) ? CW : ilid_pkg::INDEX_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic                  accept;
    logic [XW-1:0]         idx_x;
    logic [XW-1:0]         cnt_x;
    logic                  past;
    logic                  ok;
    ilid_pkg::status_t     status;
    ilid_pkg::opcode_t     opcode;
    ilid_pkg::cell_ctrl_t  ctrl;
    logic [WORD_BITS-1:0]  value_word;
    logic [WORD_BITS-1:0]  rd_word;

    logic [WORD_BITS-1:0]  entries  [CAPACITY];
    logic [WORD_BITS-1:0]  rd_parts [CAPACITY];

    logic [CW-1:0]                          count_reg;
    logic [CW-1:0]                          count_next;
    logic                                   m_valid_reg;
    logic                                   m_valid_next;
    logic [ilid_pkg::VALUE_BITS-1:0]        m_read_data_reg;
    logic [ilid_pkg::COUNT_BITS-1:0]        m_count_reg;
    logic                                   m_past_end_reg;
    logic [ilid_pkg::STATUS_BITS-1:0]       m_status_reg;

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign opcode     = ilid_pkg::opcode_t'(s_opcode);
    assign idx_x      = XW'(s_index);
    assign cnt_x      = XW'(count_reg);
    assign past       = (idx_x >= cnt_x);
    assign value_word = WORD_BITS'(s_value);

    always_comb begin
        status = ilid_pkg::ST_OK;
        unique case (opcode)
            ilid_pkg::OP_READ, ilid_pkg::OP_WRITE: begin
                if (past) begin
                    status = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::OP_INSERT: begin
                if (count_reg == FULL_COUNT) begin
                    status = ilid_pkg::ST_FULL;
                end else if (idx_x > cnt_x) begin
                    status = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::OP_DELETE: begin
                if (count_reg == '0) begin
                    status = ilid_pkg::ST_EMPTY;
                end else if (past) begin
                    status = ilid_pkg::ST_RANGE;
                end
            end
            default: status = ilid_pkg::ST_OK;
        endcase
    end

    assign ok          = accept && (status == ilid_pkg::ST_OK);
    assign ctrl.rd_en  = ok && (opcode == ilid_pkg::OP_READ);
    assign ctrl.wr_en  = ok && (opcode == ilid_pkg::OP_WRITE);
    assign ctrl.ins_en = ok && (opcode == ilid_pkg::OP_INSERT);
    assign ctrl.del_en = ok && (opcode == ilid_pkg::OP_DELETE);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [WORD_BITS-1:0] left_entry;
            logic [WORD_BITS-1:0] right_entry;

            if (gi == 0) begin : g_first
                assign left_entry = '0;
            end else begin : g_mid_l
                assign left_entry = entries[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_entry = entries[gi];
            end else begin : g_mid_r
                assign right_entry = entries[gi+1];
            end

            ilid_cell #(
                .WORD_BITS (WORD_BITS),
                .XW        (XW),
                .INDEX     (gi)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .idx         (idx_x),
                .value       (value_word),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entries[gi]),
                .rd_part     (rd_parts[gi])
            );
        end
    endgenerate

    // at most one cell drives a non-zero read part
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_word = rd_word | rd_parts[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins_en) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.del_en) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_data_reg <= ilid_pkg::VALUE_BITS'(rd_word);
            m_count_reg     <= ilid_pkg::COUNT_BITS'(count_next);
            m_past_end_reg  <= past;
            m_status_reg    <= status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_count     = m_count_reg;
    assign m_past_end  = m_past_end_reg;
    assign m_status    = m_status_reg;

endmodule

>>> src/ilid_checker.sv
`include "indexed_list_insert_delete_macros.svh"

module ilid_checker #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [ilid_pkg::VALUE_BITS-1:0]   m_read_data,
    input logic [ilid_pkg::COUNT_BITS-1:0]   m_count,
    input logic                              m_past_end,
    input logic [ilid_pkg::STATUS_BITS-1:0]  m_status
);

    localparam logic [ilid_pkg::COUNT_BITS-1:0] FULL_COUNT =
        ilid_pkg::COUNT_BITS'(CAPACITY);

    // a waiting result item holds until taken
    `ILID_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_count), "result item changed while stalled")

    // input is open whenever no result item waits
    `ILID_ASSERT_NOW(a_ready, aclk, aresetn, !m_valid, s_ready, "input stalled with no result item waiting")

    // an empty list is reported only with a zero count
    `ILID_ASSERT_NOW(a_empty, aclk, aresetn, m_valid && (m_status == ilid_pkg::ST_EMPTY), m_count == '0, "empty status with non-zero count")

    // a full list is reported only at capacity
    `ILID_ASSERT_NOW(a_full, aclk, aresetn, m_valid && (m_status == ilid_pkg::ST_FULL), m_count == FULL_COUNT, "full status below capacity")

    // read data only comes with a successful request
    `ILID_ASSERT_NOW(a_rdata, aclk, aresetn, m_valid && (m_read_data != '0), m_status == ilid_pkg::ST_OK && !m_past_end, "read data on a failed item")

endmodule

bind indexed_list_insert_delete ilid_checker #(.CAPACITY(CAPACITY)) u_ilid_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int LIST_CAP     = ilid_pkg::CAPACITY_DEF;
    localparam int LIST_AW      = $clog2(LIST_CAP);
    localparam int ITEMS_PHASE  = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIR_ROWS     = 20;

    typedef struct packed {
        logic [ilid_pkg::VALUE_BITS-1:0] read_data;
        logic [ilid_pkg::COUNT_BITS-1:0] count;
        logic                            past_end;
        ilid_pkg::status_t               status;
    } list_result_t;

    typedef struct {
        ilid_pkg::opcode_t               op;
        logic [ilid_pkg::INDEX_BITS-1:0] idx;
        logic [ilid_pkg::VALUE_BITS-1:0] val;
        bit                              typed;
        list_result_t                    res;
    } directed_row_t;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             s_valid     = 1'b0;
    logic                             s_ready;
    logic [ilid_pkg::OPCODE_BITS-1:0] s_opcode    = '0;
    logic [ilid_pkg::INDEX_BITS-1:0]  s_index     = '0;
    logic [ilid_pkg::VALUE_BITS-1:0]  s_value     = '0;
    logic                             m_valid;
    logic                             m_ready     = 1'b0;
    logic [ilid_pkg::VALUE_BITS-1:0]  m_read_data;
    logic [ilid_pkg::COUNT_BITS-1:0]  m_count;
    logic                             m_past_end;
    logic [ilid_pkg::STATUS_BITS-1:0] m_status;

    // predicted list contents
    logic [ilid_pkg::VALUE_BITS-1:0] list_words [LIST_CAP];
    int                              list_len = 0;

    list_result_t pending_results [$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_left      = 0;

    directed_row_t dir_rows [DIR_ROWS];

    indexed_list_insert_delete u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_index     (s_index),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_count     (m_count),
        .m_past_end  (m_past_end),
        .m_status    (m_status)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
        mismatch_count++;
    endtask

    function automatic list_result_t apply_list_request(
        input ilid_pkg::opcode_t               op,
        input logic [ilid_pkg::INDEX_BITS-1:0] idx,
        input logic [ilid_pkg::VALUE_BITS-1:0] val
    );
        list_result_t res;
        int           k;
        res          = '0;
        res.status   = ilid_pkg::ST_OK;
        res.past_end = (int'(idx) >= list_len);
        case (op)
            ilid_pkg::OP_READ: begin
                if (int'(idx) < list_len) res.read_data = list_words[idx[LIST_AW-1:0]];
                else res.status = ilid_pkg::ST_RANGE;
            end
            ilid_pkg::OP_WRITE: begin
                if (int'(idx) < list_len) list_words[idx[LIST_AW-1:0]] = val;
                else res.status = ilid_pkg::ST_RANGE;
            end
            ilid_pkg::OP_INSERT: begin
                if (list_len >= LIST_CAP) begin
                    res.status = ilid_pkg::ST_FULL;
                end else if (int'(idx) > list_len) begin
                    res.status = ilid_pkg::ST_RANGE;
                end else begin
                    for (k = list_len; k > int'(idx); k--) list_words[k] = list_words[k-1];
                    list_words[idx[LIST_AW-1:0]] = val;
                    list_len++;
                end
            end
            default: begin
                if (list_len == 0) begin
                    res.status = ilid_pkg::ST_EMPTY;
                end else if (int'(idx) >= list_len) begin
                    res.status = ilid_pkg::ST_RANGE;
                end else begin
                    for (k = int'(idx); k + 1 < list_len; k++) list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
        endcase
        res.count = list_len[ilid_pkg::COUNT_BITS-1:0];
        return res;
    endfunction

    task automatic drive_item(input ilid_pkg::opcode_t op,
                              input logic [ilid_pkg::INDEX_BITS-1:0] idx,
                              input logic [ilid_pkg::VALUE_BITS-1:0] val, input bit typed,
                              input list_result_t typed_res);
        list_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_index  <= idx;
        s_value  <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = apply_list_request(op, idx, val);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("item with nothing pending", 32'(m_count), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_read_data !== want.read_data)
                    report_mismatch("read_data", m_read_data, want.read_data);
                if (m_count !== want.count)
                    report_mismatch("count", 32'(m_count), 32'(want.count));
                if (m_past_end !== want.past_end)
                    report_mismatch("past_end", 32'(m_past_end), 32'(want.past_end));
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
            end
        end
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        list_result_t                    blank;
        ilid_pkg::opcode_t               op;
        logic [ilid_pkg::INDEX_BITS-1:0] idx;
        logic [ilid_pkg::VALUE_BITS-1:0] val;
        bit                              grow;
        int                              r;
        int                              phase;
        int                              n;

        blank = '{32'h0, 5'd0, 1'b0, ilid_pkg::ST_OK};
        grow  = 1'b1;
        dir_rows = '{
            '{ilid_pkg::OP_READ,   5'd0,  32'h1234_5678, 1'b1,
              '{32'h0, 5'd0, 1'b1, ilid_pkg::ST_RANGE}},
            '{ilid_pkg::OP_WRITE,  5'd0,  32'hdead_beef, 1'b1,
              '{32'h0, 5'd0, 1'b1, ilid_pkg::ST_RANGE}},
            '{ilid_pkg::OP_DELETE, 5'd0,  32'h0,         1'b1,
              '{32'h0, 5'd0, 1'b1, ilid_pkg::ST_EMPTY}},
            '{ilid_pkg::OP_DELETE, 5'd31, 32'h0,         1'b1,
              '{32'h0, 5'd0, 1'b1, ilid_pkg::ST_EMPTY}},
            '{ilid_pkg::OP_INSERT, 5'd1,  32'h0bad_0bad, 1'b1,
              '{32'h0, 5'd0, 1'b1, ilid_pkg::ST_RANGE}},
            '{ilid_pkg::OP_INSERT, 5'd0,  32'hffff_ffff, 1'b1,
              '{32'h0, 5'd1, 1'b1, ilid_pkg::ST_OK}},
            '{ilid_pkg::OP_INSERT, 5'd1,  32'h0000_0000, 1'b1,
              '{32'h0, 5'd2, 1'b1, ilid_pkg::ST_OK}},
            '{ilid_pkg::OP_INSERT, 5'd0,  32'h5555_5555, 1'b0, blank},
            '{ilid_pkg::OP_INSERT, 5'd1,  32'haaaa_aaaa, 1'b0, blank},
            '{ilid_pkg::OP_READ,   5'd0,  32'h0,         1'b0, blank},
            '{ilid_pkg::OP_READ,   5'd1,  32'h0,         1'b0, blank},
            '{ilid_pkg::OP_READ,   5'd3,  32'h0,         1'b0, blank},
            '{ilid_pkg::OP_READ,   5'd4,  32'h0,         1'b1,
              '{32'h0, 5'd4, 1'b1, ilid_pkg::ST_RANGE}},
            '{ilid_pkg::OP_WRITE,  5'd3,  32'h8000_0001, 1'b0, blank},
            '{ilid_pkg::OP_WRITE,  5'd31, 32'h7fff_fffe, 1'b1,
              '{32'h0, 5'd4, 1'b1, ilid_pkg::ST_RANGE}},
            '{ilid_pkg::OP_DELETE, 5'd1,  32'h0,         1'b0, blank},
            '{ilid_pkg::OP_DELETE, 5'd0,  32'h0,         1'b0, blank},
            '{ilid_pkg::OP_DELETE, 5'd1,  32'h0,         1'b0, blank},
            '{ilid_pkg::OP_DELETE, 5'd16, 32'h0,         1'b1,
              '{32'h0, 5'd1, 1'b1, ilid_pkg::ST_RANGE}},
            '{ilid_pkg::OP_READ,   5'd0,  32'h0,         1'b0, blank}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++) begin
            drive_item(dir_rows[n].op, dir_rows[n].idx, dir_rows[n].val,
                       dir_rows[n].typed, dir_rows[n].res);
        end

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_left      = HOLD_CYCLES;
                end
            endcase
            for (n = 0; n < ITEMS_PHASE; n++) begin
                // swing the list between full and empty
                if (list_len == LIST_CAP && $urandom_range(3) == 0) grow = 1'b0;
                if (list_len == 0 && $urandom_range(3) == 0) grow = 1'b1;
                r = $urandom_range(99);
                if (r < 50) op = grow ? ilid_pkg::OP_INSERT : ilid_pkg::OP_DELETE;
                else if (r < 65) op = grow ? ilid_pkg::OP_DELETE : ilid_pkg::OP_INSERT;
                else if (r < 85) op = ilid_pkg::OP_READ;
                else op = ilid_pkg::OP_WRITE;
                r = $urandom_range(9);
                if (r < 8) idx = ilid_pkg::INDEX_BITS'($urandom_range(list_len));
                else if (r == 8) idx = ilid_pkg::INDEX_BITS'($urandom_range(LIST_CAP));
                else idx = ilid_pkg::INDEX_BITS'($urandom_range(31));
                r = $urandom_range(9);
                if (r == 0) val = '0;
                else if (r == 1) val = '1;
                else val = $urandom;
                drive_item(op, idx, val, 1'b0, blank);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/ilid_pkg.sv
src/ilid_cell.sv
src/indexed_list_insert_delete.sv
src/ilid_checker.sv
tb/tb_top.sv
